@@ rtl/ghp_pkg.sv @@
`default_nettype none

package ghp_pkg;

  // Request kinds
  localparam logic [1:0] REQ_ACQUIRE = 2'd0;
  localparam logic [1:0] REQ_RELEASE = 2'd1;
  localparam logic [1:0] REQ_GEN     = 2'd2;
  localparam logic [1:0] REQ_DECODE  = 2'd3;

  // Status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [7:0]  slot_in;
    logic [31:0] handle_in;
  } ghp_req_t;

  typedef struct packed {
    logic [7:0]  slot_out;
    logic [31:0] handle_out;
    logic [1:0]  status;
  } ghp_res_t;

  // Free stack condition seen by the request decoder
  typedef struct packed {
    logic empty;
    logic full;
  } ghp_stk_stat_t;

endpackage

`default_nettype wire

@@ rtl/ghp_stack.sv @@
`default_nettype none

module ghp_stack #(
  parameter int NUM_SLOTS = 255
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   push,
  input  wire logic                   pop,
  input  wire logic [7:0]             push_slot,
  output ghp_pkg::ghp_stk_stat_t      stat,
  output logic [7:0]                  pop_slot
);
  import ghp_pkg::*;

  localparam int CNT_W = $clog2(NUM_SLOTS + 1);
  localparam int SI_W  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(NUM_SLOTS);
  localparam logic [CNT_W:0]   INIT_TOP = (CNT_W + 1)'(NUM_SLOTS + 1);

  logic [7:0]       stk_mem [NUM_SLOTS];
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic [CNT_W-1:0] lw_r;
  logic [CNT_W-1:0] lw_nxt;
  logic [CNT_W-1:0] top_idx;
  logic [7:0]       rd_r;
  logic             init_r;
  logic [7:0]       init_val_r;

  assign stat.empty = (count_r == '0);
  assign stat.full  = (count_r == CNT_FULL);
  assign top_idx    = count_r - CNT_W'(1);

  // Advance fill count and low-water mark; entries at or above the mark were written
  always_comb begin
    count_nxt = count_r;
    lw_nxt    = lw_r;
    if (push) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop) begin
      count_nxt = top_idx;
      if (count_r <= lw_r) begin
        lw_nxt = top_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= CNT_FULL;
      lw_r    <= CNT_FULL;
    end else begin
      count_r <= count_nxt;
      lw_r    <= lw_nxt;
    end
  end

  // Stack memory: push writes at the count, pop reads just below it
  always_ff @(posedge clk) begin
    if (push) begin
      stk_mem[count_r[SI_W-1:0]] <= push_slot;
    end
    if (pop) begin
      rd_r       <= stk_mem[top_idx[SI_W-1:0]];
      init_r     <= (count_r <= lw_r);
      init_val_r <= 8'(INIT_TOP - {1'b0, count_r});
    end
  end

  // Entries below the mark still hold their reset value
  assign pop_slot = init_r ? init_val_r : rd_r;

endmodule

`default_nettype wire

@@ rtl/ghp_gen.sv @@
`default_nettype none

module ghp_gen #(
  parameter int NUM_SLOTS = 255,
  parameter int GEN_BITS  = 24
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic [7:0]          rd_slot,
  input  wire logic                wr_en,
  input  wire logic [7:0]          wr_slot,
  output logic [GEN_BITS-1:0]      gen_new
);
  import ghp_pkg::*;

  localparam int GEN_DEPTH = (NUM_SLOTS + 1 > 256) ? 256 : NUM_SLOTS + 1;
  localparam int GA_W      = $clog2(GEN_DEPTH);

  logic [GEN_BITS-1:0]  gen_mem [GEN_DEPTH];
  logic [GEN_DEPTH-1:0] vld_r;
  logic [GA_W-1:0]      rd_addr;
  logic [GA_W-1:0]      wr_addr;
  logic [GEN_BITS-1:0]  rd_r;
  logic                 hit_r;
  logic                 fwd_r;
  logic [GEN_BITS-1:0]  fwd_val_r;
  logic [GEN_BITS-1:0]  gen_cur;

  assign rd_addr = rd_slot[GA_W-1:0];
  assign wr_addr = wr_slot[GA_W-1:0];

  // Track which entries were written since reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      hit_r <= 1'b0;
      fwd_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      hit_r <= vld_r[rd_addr];
      fwd_r <= wr_en && (wr_addr == rd_addr);
    end
  end

  // Generation memory; forward the value written in the same cycle as the read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      gen_mem[wr_addr] <= gen_new;
    end
    rd_r      <= gen_mem[rd_addr];
    fwd_val_r <= gen_new;
  end

  // Bump the generation, wrapping at the counter width
  always_comb begin
    if (fwd_r) begin
      gen_cur = fwd_val_r;
    end else if (hit_r) begin
      gen_cur = rd_r;
    end else begin
      gen_cur = '0;
    end
    gen_new = gen_cur + GEN_BITS'(1);
  end

endmodule

`default_nettype wire

@@ rtl/generational_handle_pool.sv @@
`default_nettype none

// Generational handle pool: slots 1..NUM_SLOTS on a LIFO free stack, with a
// generation counter per slot.
// Input channel: an item (req_type, slot_in, handle_in) is taken at each
// rising edge where start is high and busy is low. busy stays low, so one
// item can be taken every cycle.
// Result channel: out_valid is high for one cycle with out_item (slot_out,
// handle_out, status); the receiver cannot stall it, results come in
// request order.
// Result path: an accepted item passes the input and memory read registers,
// then the result register. Throughput: 1 item per cycle; the generation
// read-modify-write is forwarded, so back-to-back requests to the same slot
// see the latest count.
// Reset (rst_n low, synchronous): the stack holds every slot so the first
// acquire yields slot 1, all generations read as zero. No clearing pass:
// a low-water mark and per-slot valid bits stand in for the reset contents,
// so the block takes items from the first cycle after reset.
module generational_handle_pool #(
  parameter int NUM_SLOTS = 255,
  parameter int SLOT_BITS = 8
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire ghp_pkg::ghp_req_t   in_item,
  output logic                     busy,
  output logic                     out_valid,
  output ghp_pkg::ghp_res_t        out_item
);
  import ghp_pkg::*;

  localparam int          GEN_BITS  = 32 - SLOT_BITS;
  localparam logic [31:0] SLOT_MASK = 32'((64'd1 << SLOT_BITS) - 64'd1);

  logic            accept;
  logic            slot_ok;
  logic            push;
  logic            pop;
  logic [1:0]      status_nxt;
  ghp_stk_stat_t   stk_stat;
  logic [7:0]      pop_slot;
  logic [GEN_BITS-1:0] gen_new;
  logic            gen_wr;

  logic            s1_vld_r;
  logic [1:0]      s1_req_r;
  logic [7:0]      s1_slot_r;
  logic [31:0]     s1_handle_r;
  logic [1:0]      s1_status_r;

  ghp_res_t        res_nxt;
  logic            out_vld_r;
  ghp_res_t        out_r;

  assign busy    = 1'b0;
  assign accept  = start && !busy;
  assign slot_ok = (in_item.slot_in != 8'd0) &&
                   (32'(in_item.slot_in) <= 32'(NUM_SLOTS));

  // Decode request against the stack condition
  always_comb begin
    push       = 1'b0;
    pop        = 1'b0;
    status_nxt = ST_OK;
    case (in_item.req_type)
      REQ_ACQUIRE: begin
        if (stk_stat.empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          pop = accept;
        end
      end
      REQ_RELEASE: begin
        if (!slot_ok) begin
          status_nxt = ST_RANGE;
        end else if (stk_stat.full) begin
          status_nxt = ST_FULL;
        end else begin
          push = accept;
        end
      end
      REQ_GEN: begin
        if (!slot_ok) begin
          status_nxt = ST_RANGE;
        end
      end
      default: begin
        status_nxt = ST_OK;
      end
    endcase
  end

  ghp_stack #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_stack (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .pop       (pop),
    .push_slot (in_item.slot_in),
    .stat      (stk_stat),
    .pop_slot  (pop_slot)
  );

  assign gen_wr = s1_vld_r && (s1_req_r == REQ_GEN) && (s1_status_r == ST_OK);

  ghp_gen #(
    .NUM_SLOTS (NUM_SLOTS),
    .GEN_BITS  (GEN_BITS)
  ) u_gen (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_slot (in_item.slot_in),
    .wr_en   (gen_wr),
    .wr_slot (s1_slot_r),
    .gen_new (gen_new)
  );

  // Hold the accepted item alongside the memory reads
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_req_r    <= in_item.req_type;
      s1_slot_r   <= in_item.slot_in;
      s1_handle_r <= in_item.handle_in;
      s1_status_r <= status_nxt;
    end
  end

  // Form the result item
  always_comb begin
    res_nxt.slot_out   = 8'd0;
    res_nxt.handle_out = 32'd0;
    res_nxt.status     = s1_status_r;
    case (s1_req_r)
      REQ_ACQUIRE: begin
        if (s1_status_r == ST_OK) begin
          res_nxt.slot_out = pop_slot;
        end
      end
      REQ_GEN: begin
        if (s1_status_r == ST_OK) begin
          res_nxt.handle_out = (32'(gen_new) << SLOT_BITS) |
                               (32'(s1_slot_r) & SLOT_MASK);
        end
      end
      REQ_DECODE: begin
        res_nxt.slot_out = 8'(s1_handle_r & SLOT_MASK);
      end
      default: begin
        res_nxt.slot_out = 8'd0;
      end
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_vld_r) begin
      out_r <= res_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_item  = out_r;

endmodule

`default_nettype wire
